@@ src/register_group_pec15_checker_core_macros.svh @@
// Assertion macros shared by the PEC15 checker's assertion files.
// Depends on a clock named clk and an active-high reset named rst in scope.
`ifndef REGISTER_GROUP_PEC15_CHECKER_CORE_MACROS_SVH
`define REGISTER_GROUP_PEC15_CHECKER_CORE_MACROS_SVH

// Checked on every edge outside reset.
`define RGPEC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every edge, reset included.
`define RGPEC_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ src/rgpec_pkg.sv @@
// Shared types, constants and the PEC15 table function for the checker.
// No dependencies.
package rgpec_pkg;

  localparam int MAX_DEVICES_DEF      = 16;
  localparam int FRAME_DATA_BYTES_DEF = 6;
  localparam int READING_BYTES        = 6;
  localparam int QUEUE_DEPTH          = 4;
  localparam int POS_W                = 3;
  localparam int DEV_W                = 4;
  localparam int CHAIN_W              = 5;

  localparam logic [15:0] PEC_SEED = 16'h0010;
  localparam logic [15:0] PEC_POLY = 16'h4599;

  typedef enum logic [1:0] {
    KIND_DATA,
    KIND_PEC_HI,
    KIND_PEC_LO
  } byte_kind_t;

  typedef struct packed {
    logic [7:0]       data_byte;
    logic [POS_W-1:0] pos;
    byte_kind_t       kind;
    logic             first;
    logic             start;
  } rx_item_t;

  // One entry of the byte-wise PEC15 table.
  function automatic logic [15:0] pec_table_entry(input logic [7:0] idx);
    logic [15:0] rem;
    rem = {1'b0, idx, 7'b0};
    for (int b = 0; b < 8; b++) begin
      if (rem[14]) begin
        rem = {rem[14:0], 1'b0} ^ PEC_POLY;
      end else begin
        rem = {rem[14:0], 1'b0};
      end
    end
    return rem;
  endfunction

endpackage

@@ src/rgpec_front.sv @@
// Front end: tracks the byte position in the frame and classifies each byte.
// Depends on rgpec_pkg.
module rgpec_front import rgpec_pkg::*; #(
  parameter int FRAME_DATA_BYTES = FRAME_DATA_BYTES_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic [7:0] data_byte,
  input  logic       frame_start,
  input  logic       accept,
  output rx_item_t   item
);

  localparam logic [POS_W-1:0] PEC_HI_POS = POS_W'(FRAME_DATA_BYTES);
  localparam logic [POS_W-1:0] PEC_LO_POS = POS_W'(FRAME_DATA_BYTES + 1);

  logic [POS_W-1:0] byte_position;
  logic [POS_W-1:0] byte_position_next;
  logic [POS_W-1:0] pos;

  always_comb begin
    pos = frame_start ? '0 : byte_position;
    item.data_byte = data_byte;
    item.pos       = pos;
    item.first     = (pos == '0);
    item.start     = frame_start;
    if (pos < PEC_HI_POS) begin
      item.kind = KIND_DATA;
    end else if (pos == PEC_HI_POS) begin
      item.kind = KIND_PEC_HI;
    end else begin
      item.kind = KIND_PEC_LO;
    end
    byte_position_next = (pos == PEC_LO_POS) ? '0 : pos + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= '0;
    end else if (accept) begin
      byte_position <= byte_position_next;
    end
  end

endmodule

@@ src/rgpec_queue.sv @@
// Small FIFO of classified bytes between front and back end.
// Depends on rgpec_pkg.
module rgpec_queue import rgpec_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  rx_item_t push_item,
  output logic     full,
  input  logic     pop,
  output logic     avail,
  output rx_item_t head
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  rx_item_t         slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full  = (count == FULL_CNT);
  assign avail = (count != '0);
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

@@ src/rgpec_back.sv @@
// Back end: PEC15 update, frame assembly, device count and output register.
// Depends on rgpec_pkg.
module rgpec_back import rgpec_pkg::*; #(
  parameter int MAX_DEVICES = MAX_DEVICES_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic [CHAIN_W-1:0] chain_length,
  input  logic               avail,
  input  rx_item_t           head,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [15:0]        value_a,
  output logic [15:0]        value_b,
  output logic [15:0]        value_c,
  output logic               pec_ok,
  output logic [DEV_W-1:0]   device_index,
  output logic               last_device
);

  localparam logic [CHAIN_W-1:0] MAX_CHAIN = CHAIN_W'(MAX_DEVICES);

  logic [15:0]        crc_remainder;
  logic [15:0]        crc_base;
  logic [15:0]        crc_next;
  logic [7:0]         dbytes [READING_BYTES];
  logic [7:0]         pec_high_byte;
  logic [DEV_W-1:0]   device_counter;
  logic [DEV_W-1:0]   dev_base;
  logic [CHAIN_W-1:0] eff_len;
  logic               is_last;
  logic               emit;

  // Only a final PEC byte needs room in the output register.
  assign pop  = avail && ((head.kind != KIND_PEC_LO) || !out_valid || out_ready);
  assign emit = pop && (head.kind == KIND_PEC_LO);

  always_comb begin
    crc_base = head.first ? PEC_SEED : crc_remainder;
    crc_next = {crc_base[7:0], 8'h00} ^ pec_table_entry(crc_base[14:7] ^ head.data_byte);
    dev_base = head.start ? '0 : device_counter;
    if (chain_length == '0) begin
      eff_len = CHAIN_W'(1);
    end else if (chain_length > MAX_CHAIN) begin
      eff_len = MAX_CHAIN;
    end else begin
      eff_len = chain_length;
    end
    is_last = ({1'b0, dev_base} >= (eff_len - 1'b1));
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      if (head.kind == KIND_DATA) begin
        crc_remainder <= crc_next;
      end
      if (head.kind == KIND_PEC_HI) begin
        pec_high_byte <= head.data_byte;
      end
      for (int i = 0; i < READING_BYTES; i++) begin
        if ((head.kind == KIND_DATA) && (head.pos == POS_W'(i))) begin
          dbytes[i] <= head.data_byte;
        end else if (head.first) begin
          dbytes[i] <= 8'h00;
        end
      end
    end
    if (emit) begin
      value_a      <= {dbytes[1], dbytes[0]};
      value_b      <= {dbytes[3], dbytes[2]};
      value_c      <= {dbytes[5], dbytes[4]};
      pec_ok       <= ({pec_high_byte, head.data_byte} == {crc_remainder[14:0], 1'b0});
      device_index <= dev_base;
      last_device  <= is_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      device_counter <= '0;
      out_valid      <= 1'b0;
    end else begin
      if (emit) begin
        device_counter <= is_last ? '0 : dev_base + 1'b1;
      end else if (pop && head.start) begin
        device_counter <= '0;
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

@@ src/register_group_pec15_checker_core.sv @@
// channel   dir  handshake                 payload
// s_axis    in   s_tvalid / s_tready       tdata: data_byte; tuser: frame_start
// m_axis    out  m_tvalid / m_tready       tdata: readings, device_index;
//                                          tuser: pec_ok; tlast: last_device
// cfg       in   cfg_wr_en                 cfg_wr_data: chain_length
//
// One byte per cycle sustained while the queue has room; the PEC15 table update is combinational.
// A byte reaches the back end through the queue; a frame result
// is valid on m_tdata from the edge at which its last PEC byte leaves the queue.
// Reset clears framing, queue and device count; chain_length returns to 1.
// A stalled output only blocks final PEC bytes; the 4-entry queue absorbs
// input while the output register waits.
// Top level of the register-group PEC15 checker. Depends on rgpec_pkg,
// rgpec_front, rgpec_queue and rgpec_back.
module register_group_pec15_checker_core import rgpec_pkg::*; #(
  parameter int MAX_DEVICES      = MAX_DEVICES_DEF,
  parameter int FRAME_DATA_BYTES = FRAME_DATA_BYTES_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic [7:0]         s_tdata,     // [7:0] data_byte
  input  logic               s_tuser,     // [0] frame_start
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic [55:0]        m_tdata,     // value_a, value_b, value_c, device_index, pad
  output logic               m_tuser,     // [0] pec_ok
  output logic               m_tlast,
  input  logic               cfg_wr_en,
  input  logic [CHAIN_W-1:0] cfg_wr_data
);

  logic [CHAIN_W-1:0] chain_length;
  rx_item_t           front_item;
  rx_item_t           head;
  logic               accept;
  logic               q_full;
  logic               q_avail;
  logic               q_pop;
  logic [15:0]        value_a;
  logic [15:0]        value_b;
  logic [15:0]        value_c;
  logic [DEV_W-1:0]   device_index;

  assign s_tready = !q_full;
  assign accept   = s_tvalid && s_tready;
  assign m_tdata  = {4'b0000, device_index, value_c, value_b, value_a};

  always_ff @(posedge clk) begin
    if (rst) begin
      chain_length <= CHAIN_W'(1);
    end else if (cfg_wr_en) begin
      chain_length <= cfg_wr_data;
    end
  end

  rgpec_front #(
    .FRAME_DATA_BYTES(FRAME_DATA_BYTES)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .data_byte  (s_tdata),
    .frame_start(s_tuser),
    .accept     (accept),
    .item       (front_item)
  );

  rgpec_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (accept),
    .push_item(front_item),
    .full     (q_full),
    .pop      (q_pop),
    .avail    (q_avail),
    .head     (head)
  );

  rgpec_back #(
    .MAX_DEVICES(MAX_DEVICES)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .chain_length(chain_length),
    .avail       (q_avail),
    .head        (head),
    .pop         (q_pop),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .value_a     (value_a),
    .value_b     (value_b),
    .value_c     (value_c),
    .pec_ok      (m_tuser),
    .device_index(device_index),
    .last_device (m_tlast)
  );

endmodule

@@ src/rgpec_checker.sv @@
// Port-level assertions for the PEC15 checker, bound to the top level.
// Depends on rgpec_pkg and register_group_pec15_checker_core_macros.svh.
`include "register_group_pec15_checker_core_macros.svh"

module rgpec_checker import rgpec_pkg::*; #(
  parameter int MAX_DEVICES = MAX_DEVICES_DEF
) (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [55:0] m_tdata,
  input logic        m_tuser,
  input logic        m_tlast
);

  localparam logic [DEV_W-1:0] TOP_DEV = DEV_W'(MAX_DEVICES - 1);

  `RGPEC_ASSERT(a_hold_valid, m_tvalid && !m_tready |=> m_tvalid, "result dropped while stalled")
  `RGPEC_ASSERT(a_hold_data, m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast), "result changed while stalled")
  `RGPEC_ASSERT_ALWAYS(a_reset_idle, rst |=> !m_tvalid, "result valid right after reset")
  `RGPEC_ASSERT(a_top_dev_last, m_tvalid && (m_tdata[51:48] == TOP_DEV) |-> m_tlast, "highest device not flagged last")

endmodule

bind register_group_pec15_checker_core rgpec_checker #(
  .MAX_DEVICES(MAX_DEVICES)
) u_rgpec_checker (
  .clk     (clk),
  .rst     (rst),
  .m_tvalid(m_tvalid),
  .m_tready(m_tready),
  .m_tdata (m_tdata),
  .m_tuser (m_tuser),
  .m_tlast (m_tlast)
);

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for register_group_pec15_checker_core: streams readback bytes,
// predicts each frame's readings, PEC flag and device position, and checks the results.
// Depends on rgpec_pkg and the checker RTL.
module tb_top import rgpec_pkg::*; ;

  localparam int DATA_BYTES  = FRAME_DATA_BYTES_DEF;
  localparam int STALL_LIMIT = 2000;
  localparam int SETTLE_GAP  = 16;
  localparam int PHASE_ITEMS = 210;

  typedef struct {
    logic [7:0] data;
    logic       start;
    logic       hold;   // present only once every result is back
  } link_byte_t;

  typedef struct {
    logic [15:0] value_a;
    logic [15:0] value_b;
    logic [15:0] value_c;
    logic        pec_ok;
    logic [3:0]  device_index;
    logic        last_device;
  } frame_result_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               s_tvalid = 1'b0;
  logic               s_tready;
  logic [7:0]         s_tdata = '0;
  logic               s_tuser = 1'b0;
  logic               m_tvalid;
  logic               m_tready = 1'b0;
  logic [55:0]        m_tdata;
  logic               m_tuser;
  logic               m_tlast;
  logic               cfg_wr_en = 1'b0;
  logic [CHAIN_W-1:0] cfg_wr_data = '0;

  link_byte_t    link_bytes_pending[$];
  frame_result_t expected_frames[$];

  // Predictor state: mirrors the block's framing and CRC registers.
  logic [14:0]        pec_rem = PEC_SEED[14:0];
  logic [2:0]         frame_pos = '0;
  logic [47:0]        reading_bytes = '0;
  logic [7:0]         pec_hi = '0;
  logic [3:0]         dev_count = '0;
  logic [CHAIN_W-1:0] chain_cfg = 5'd1;

  logic in_taken = 1'b0;
  int   send_idle_pct = 0;
  int   recv_idle_pct = 0;
  int   mismatches = 0;
  int   bytes_queued = 0;
  int   bytes_taken = 0;
  int   frames_seen = 0;
  int   bad_pec_seen = 0;
  int   chain_writes = 0;
  int   stall_cycles = 0;

  register_group_pec15_checker_core dut (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser),
    .m_tlast     (m_tlast),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Bit-serial PEC15 step over one byte, MSB first, on a 15-bit remainder.
  function automatic logic [14:0] pec15_next(input logic [14:0] rem, input logic [7:0] b);
    logic [14:0] r;
    logic        fb;
    r = rem;
    for (int i = 7; i >= 0; i--) begin
      fb = r[14] ^ b[i];
      r = {r[13:0], 1'b0};
      if (fb) begin
        r = r ^ PEC_POLY[14:0];
      end
    end
    return r;
  endfunction

  task automatic track_readback_byte(input logic [7:0] b, input logic start);
    frame_result_t      res;
    logic [CHAIN_W-1:0] eff;
    logic               last;
    if (start) begin
      frame_pos = '0;
      dev_count = '0;
    end
    if (frame_pos == 0) begin
      pec_rem = PEC_SEED[14:0];
      reading_bytes = '0;
    end
    if (frame_pos < DATA_BYTES) begin
      pec_rem = pec15_next(pec_rem, b);
      reading_bytes[8*frame_pos +: 8] = b;
      frame_pos = frame_pos + 1'b1;
    end else if (frame_pos == DATA_BYTES) begin
      pec_hi = b;
      frame_pos = frame_pos + 1'b1;
    end else begin
      // 0 acts as one device, anything past the maximum as the maximum
      eff = chain_cfg;
      if (eff == 0) begin
        eff = CHAIN_W'(1);
      end
      if (eff > MAX_DEVICES_DEF) begin
        eff = CHAIN_W'(MAX_DEVICES_DEF);
      end
      last = ({1'b0, dev_count} >= eff - 1'b1);
      res.value_a      = reading_bytes[15:0];
      res.value_b      = reading_bytes[31:16];
      res.value_c      = reading_bytes[47:32];
      res.pec_ok       = ({pec_hi, b} == {pec_rem, 1'b0});
      res.device_index = dev_count;
      res.last_device  = last;
      expected_frames.push_back(res);
      dev_count = last ? 4'd0 : dev_count + 1'b1;
      frame_pos = '0;
    end
  endtask

  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  // Stream driver: next transaction goes out once the current one is taken.
  always @(negedge clk) begin
    link_byte_t nxt;
    if (!s_tvalid || in_taken) begin
      if (link_bytes_pending.size() != 0
          && !(link_bytes_pending[0].hold && expected_frames.size() != 0)
          && $urandom_range(0, 99) >= send_idle_pct) begin
        nxt = link_bytes_pending.pop_front();
        s_tvalid <= 1'b1;
        s_tdata  <= nxt.data;
        s_tuser  <= nxt.start;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    frame_result_t want;
    in_taken <= s_tvalid && s_tready;
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        bytes_taken++;
        track_readback_byte(s_tdata, s_tuser);
      end
      if (m_tvalid && m_tready) begin
        frames_seen++;
        if (expected_frames.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual tdata %0h tuser %0b tlast %0b",
                   $time, m_tdata, m_tuser, m_tlast);
          mismatches++;
        end else begin
          want = expected_frames.pop_front();
          if (!want.pec_ok) begin
            bad_pec_seen++;
          end
          check_field("value_a", want.value_a, m_tdata[15:0]);
          check_field("value_b", want.value_b, m_tdata[31:16]);
          check_field("value_c", want.value_c, m_tdata[47:32]);
          check_field("device_index", want.device_index, m_tdata[51:48]);
          check_field("pec_ok", want.pec_ok, m_tuser);
          check_field("last_device", want.last_device, m_tlast);
        end
      end
    end
  end

  // Watchdog: only counts while work is outstanding.
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)
        || (link_bytes_pending.size() == 0 && !s_tvalid && expected_frames.size() == 0)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("register_group_pec15_checker_core verification failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic queue_byte(input logic [7:0] b, input logic start, input logic hold);
    link_byte_t item;
    item.data  = b;
    item.start = start;
    item.hold  = hold;
    link_bytes_pending.push_back(item);
    bytes_queued++;
  endtask

  // One register-group frame; fill < 0 means random data bytes.
  task automatic queue_frame(input logic start, input logic bad_pec, input logic hold,
                             input int fill);
    logic [7:0]  d[DATA_BYTES];
    logic [14:0] rem;
    logic [15:0] pec;
    rem = PEC_SEED[14:0];
    for (int i = 0; i < DATA_BYTES; i++) begin
      d[i] = (fill < 0) ? 8'($urandom_range(0, 255)) : 8'(fill);
      rem = pec15_next(rem, d[i]);
    end
    pec = {rem, 1'b0};
    if (bad_pec) begin
      pec = pec ^ (16'd1 << $urandom_range(0, 15));
    end
    for (int i = 0; i < DATA_BYTES; i++) begin
      queue_byte(d[i], start && i == 0, hold && i == 0);
    end
    queue_byte(pec[15:8], 1'b0, 1'b0);
    queue_byte(pec[7:0], 1'b0, 1'b0);
  endtask

  task automatic wait_idle();
    while (link_bytes_pending.size() != 0 || s_tvalid || expected_frames.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_GAP) @(posedge clk);
  endtask

  task automatic write_chain(input logic [CHAIN_W-1:0] v);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    chain_cfg = v;
    chain_writes++;
  endtask

  task automatic queue_random_traffic(input int count);
    int   stop_at;
    int   eff;
    int   pick;
    logic first_frame;
    stop_at = bytes_queued + count;
    while (bytes_queued < stop_at) begin
      eff = (chain_cfg == 0) ? 1 : (chain_cfg > MAX_DEVICES_DEF) ? MAX_DEVICES_DEF : chain_cfg;
      pick = $urandom_range(0, 99);
      if (pick < 80) begin
        // full transfer, sometimes one frame past the chain to hit the wrap
        first_frame = 1'b1;
        for (int f = $urandom_range(1, eff + 1); f > 0; f--) begin
          queue_frame(first_frame, $urandom_range(0, 9) == 0,
                      $urandom_range(0, 99) == 0, -1);
          first_frame = 1'b0;
        end
      end else if (pick < 90) begin
        for (int f = $urandom_range(1, 3); f > 0; f--) begin
          queue_frame(1'b0, $urandom_range(0, 9) == 0, 1'b0, -1);
        end
      end else begin
        for (int n = $urandom_range(1, 12); n > 0; n--) begin
          queue_byte(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0, 1'b0);
        end
      end
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: extremes, bad PEC, device wrap and a mid-frame resync.
    send_idle_pct = 24;
    recv_idle_pct = 81;
    write_chain(5'd2);
    queue_frame(1'b1, 1'b0, 1'b0, 8'h00);
    queue_frame(1'b0, 1'b1, 1'b0, 8'hFF);
    queue_byte(8'h5A, 1'b0, 1'b1);
    queue_byte(8'hA5, 1'b0, 1'b0);
    queue_byte(8'h5A, 1'b0, 1'b0);
    queue_frame(1'b1, 1'b0, 1'b0, 8'hA5);
    wait_idle();

    for (int ph = 0; ph < 6; ph++) begin
      send_idle_pct = (ph < 2) ? 24 : (ph < 4) ? 81 : 0;
      recv_idle_pct = (ph < 2) ? 81 : (ph < 4) ? 24 : 0;
      case (ph)
        0: write_chain(5'd0);
        1: begin
          // lower the chain while the device count is already past its end
          write_chain(5'd16);
          queue_frame(1'b1, 1'b0, 1'b0, -1);
          for (int f = 0; f < 9; f++) begin
            queue_frame(1'b0, 1'b0, 1'b0, -1);
          end
          wait_idle();
          write_chain(5'd3);
          for (int f = 0; f < 4; f++) begin
            queue_frame(1'b0, 1'b0, 1'b0, -1);
          end
        end
        2: write_chain(5'd31);
        3: write_chain(5'd1);
        4: write_chain(5'($urandom_range(1, 16)));
        default: write_chain(5'd16);
      endcase
      queue_random_traffic(PHASE_ITEMS);
      wait_idle();
    end

    $display("Run covered %0d input transactions and %0d frame results (%0d with PEC errors),",
             bytes_taken, frames_seen, bad_pec_seen);
    $display("over %0d chain-length writes incl. 0, 1, 16, 31 and a chain lowered mid-transfer.",
             chain_writes);
    if (mismatches == 0 && expected_frames.size() == 0) begin
      $display("register_group_pec15_checker_core verification clean");
    end else begin
      $display("register_group_pec15_checker_core verification failed");
    end
    $finish;
  end

endmodule
